// ===== hw/rtl/i16mp_pkg.sv =====
// shared constants and types for the int16 mac / relu / max-pool layer engine
// used by the engine top level and its port checker
`default_nettype none

package i16mp_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned InDataW  = 2 * DataW;

  localparam logic [KindW-1:0]  LayerConv = 2'd0;
  localparam logic [KindW-1:0]  LayerFc   = 2'd1;
  localparam logic [KindW-1:0]  LayerPool = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgLayerKind = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgConvShift = 2'd1;

  localparam logic [KindW-1:0]  KindReset  = LayerConv;
  localparam logic [ShiftW-1:0] ShiftReset = 4'd3;

  localparam logic [DataW-1:0] AccReset = '0;
  localparam logic [DataW-1:0] MaxReset = {1'b1, {(DataW-1){1'b0}}};

  typedef logic [DataW-1:0] word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/int16_layer_mac_pool_engine.sv =====
// int16 layer engine: multiply-accumulate, relu or max-pool per input beat
// depends on i16mp_pkg
// path: a beat with tlast is held in the input register, then its result is written to the result
//   register, which drives tvalid; it waits in the input register while an unread result blocks it
// throughput: one input beat per cycle; the input register and the result
//   register each hold one beat, so input flow stops only while a finished
//   result sits unread and another last beat waits behind it
// reset: accumulator to 0, running max to -32768, layer_kind to 0, conv_shift to 3
`default_nettype none

module int16_layer_mac_pool_engine
  import i16mp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,   // [15:0] activation, [31:16] weight
  input  wire logic                s_axis_tlast_i,
  // result stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [DataW-1:0]         m_axis_tdata_o    // [15:0] result
);

  logic [KindW-1:0]  kind_q;
  logic [ShiftW-1:0] shift_q;

  logic  in_valid_q, in_last_q;
  word_t in_act_q, in_wgt_q;

  word_t acc_q, acc_d;
  word_t max_q, max_d;

  logic  out_valid_q, out_valid_d;
  word_t res_q, res_d;

  logic  out_free, in_adv, in_take;
  word_t prod, sum, mx, shifted;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KindReset;
      shift_q <= ShiftReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgLayerKind: kind_q  <= cfg_data_i[KindW-1:0];
        CfgConvShift: shift_q <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // a non-last beat never needs the result register
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_adv          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || in_adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_act_q  <= s_axis_tdata_i[DataW-1:0];
      in_wgt_q  <= s_axis_tdata_i[InDataW-1:DataW];
      in_last_q <= s_axis_tlast_i;
    end
  end

  // low half of the product is the same signed or unsigned
  assign prod    = word_t'(in_act_q * in_wgt_q);
  assign sum     = acc_q + prod;
  assign mx      = ($signed(in_act_q) > $signed(max_q)) ? in_act_q : max_q;
  assign shifted = word_t'($signed(sum) >>> shift_q);

  always_comb begin
    acc_d       = acc_q;
    max_d       = max_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (in_adv) begin
      if (in_last_q) begin
        acc_d       = AccReset;
        max_d       = MaxReset;
        out_valid_d = 1'b1;
        case (kind_q)
          LayerConv: res_d = shifted;
          LayerFc:   res_d = sum[DataW-1] ? '0 : sum;
          default:   res_d = mx;  // pool, and the unused fourth code
        endcase
      end else begin
        acc_d = sum;
        max_d = mx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= AccReset;
      max_q       <= MaxReset;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/i16mp_port_checker.sv =====
// port-level checks for int16_layer_mac_pool_engine, bound to the top level
// depends on i16mp_pkg
`default_nettype none

module i16mp_port_checker
  import i16mp_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid_i,
  input wire logic               s_axis_tready_o,
  input wire logic               s_axis_tlast_i,
  input wire logic               m_axis_tvalid_o,
  input wire logic               m_axis_tready_i,
  input wire logic [DataW-1:0]   m_axis_tdata_o
);

  logic s_last_beat;
  assign s_last_beat = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;

  // a fresh result comes from an accepted last input beat
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_last_beat, 2))
    else $error("result appeared without a last input beat");

  // input side never stalls while the result side is empty
  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped before it was taken");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

endmodule

bind int16_layer_mac_pool_engine i16mp_port_checker u_i16mp_port_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
